// ===== src/nze_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nze_pkg
// Shared types and constants of the nonzero coordinate emitter.
// ----------------------------------------------------------------------------
package nze_pkg;

	localparam int MAX_DIMS    = 4;
	localparam int COORD_WIDTH = 16;

	// Fixed widths of the port fields.
	localparam int EXTENT_REGS = 4;
	localparam int OUT_DIMS    = 4;
	localparam int FIELD_W     = 16;
	localparam int ELEM_W      = 64;
	localparam int ORD_W       = 32;
	localparam int DIMS_W      = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// Dimensions that can actually be active.
	localparam int ACT_DIMS = (MAX_DIMS < EXTENT_REGS) ? MAX_DIMS : EXTENT_REGS;
	// Compare width wide enough for both a counter plus one and an extent.
	localparam int CMP_W = ((COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W) + 1;

	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_KIND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM0  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM1  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM2  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM3  = 3'd5;

	typedef enum logic [2:0] {
		KIND_INT       = 3'd0,
		KIND_FP16      = 3'd1,
		KIND_BF16      = 3'd2,
		KIND_FP32      = 3'd3,
		KIND_FP64      = 3'd4,
		KIND_CPLX_FP32 = 3'd5
	} kind_t;

	typedef struct packed {
		logic [2:0]                           kind;
		logic [DIMS_W-1:0]                    dims;
		logic [EXTENT_REGS-1:0][FIELD_W-1:0]  extent;
	} cfg_t;

	typedef struct packed {
		logic [OUT_DIMS-1:0][FIELD_W-1:0] coords;
		logic [ORD_W-1:0]                 ordinal;
	} hit_t;

endpackage

// ===== src/nze_zero_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nze_zero_test
// Decides whether an element is nonzero according to its element kind.
// ----------------------------------------------------------------------------
module nze_zero_test (
	input  logic [nze_pkg::ELEM_W-1:0] element_bits,
	input  logic [2:0]                 kind,
	output logic                       nonzero
);
	import nze_pkg::*;

	// Float kinds ignore the sign bit, so minus zero tests as zero.
	always_comb begin
		unique case (kind)
			KIND_FP16, KIND_BF16: begin
				nonzero = |element_bits[14:0];
			end
			KIND_FP32: begin
				nonzero = |element_bits[30:0];
			end
			KIND_FP64: begin
				nonzero = |element_bits[62:0];
			end
			KIND_CPLX_FP32: begin
				nonzero = (|element_bits[30:0]) | (|element_bits[62:32]);
			end
			default: begin
				nonzero = |element_bits;
			end
		endcase
	end

endmodule

// ===== src/nze_coord_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nze_coord_counter
// Row-major coordinate counter and running count of nonzero elements.
// ----------------------------------------------------------------------------
module nze_coord_counter (
	input  logic          clk,
	input  logic          arst_n,
	input  nze_pkg::cfg_t cfg,
	input  logic          step,
	input  logic          nonzero,
	output nze_pkg::hit_t hit
);
	import nze_pkg::*;

	logic [COORD_WIDTH-1:0] pos_q [ACT_DIMS];
	logic [COORD_WIDTH-1:0] pos_next [ACT_DIMS];
	logic [ORD_W-1:0]       hits_q;
	logic [ORD_W-1:0]       hits_next;
	logic [DIMS_W-1:0]      nd;
	logic                   wrapped;

	assign nd = (cfg.dims > DIMS_W'(ACT_DIMS)) ? DIMS_W'(ACT_DIMS) : cfg.dims;

	// Carry ripples from the innermost active dimension outward. A counter at
	// or beyond its extent wraps to zero and carries; extent zero acts as one.
	// An extent above the counter range is limited to the counter range.
	always_comb begin
		logic                   carry;
		logic [COORD_WIDTH:0]   inc;
		logic                   fits;
		carry = 1'b1;
		for (int d = ACT_DIMS - 1; d >= 0; d--) begin
			inc  = {1'b0, pos_q[d]} + (COORD_WIDTH+1)'(1);
			fits = (CMP_W'(inc) < CMP_W'(cfg.extent[d])) && !inc[COORD_WIDTH];
			if (DIMS_W'(d) < nd) begin
				if (carry) begin
					if (fits) begin
						pos_next[d] = inc[COORD_WIDTH-1:0];
						carry       = 1'b0;
					end else begin
						pos_next[d] = '0;
					end
				end else begin
					pos_next[d] = pos_q[d];
				end
			end else begin
				pos_next[d] = '0;
			end
		end
		wrapped = carry;
	end

	always_comb begin
		if (wrapped) begin
			hits_next = '0;
		end else if (nonzero) begin
			hits_next = hits_q + ORD_W'(1);
		end else begin
			hits_next = hits_q;
		end
	end

	// Unused dimensions read as zero even before their counters are cleared.
	always_comb begin
		hit.coords  = '0;
		hit.ordinal = hits_q;
		for (int d = 0; d < ACT_DIMS; d++) begin
			if (DIMS_W'(d) < nd) begin
				hit.coords[d] = FIELD_W'(pos_q[d]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < ACT_DIMS; d++) begin
				pos_q[d] <= '0;
			end
			hits_q <= '0;
		end else if (step) begin
			for (int d = 0; d < ACT_DIMS; d++) begin
				pos_q[d] <= pos_next[d];
			end
			hits_q <= hits_next;
		end
	end

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(hits_q))
		else $error("nonzero count changed without a step");

	a_scalar_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(step && nd == '0) |=> hits_q == '0)
		else $error("scalar element did not restart the count");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(step && nonzero && !wrapped) |=> hits_q == $past(hits_q) + ORD_W'(1))
		else $error("nonzero count did not advance");

endmodule

// ===== src/nonzero_coordinate_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonzero_coordinate_emitter
// Streams tensor elements and emits the coordinates of each nonzero one.
// ----------------------------------------------------------------------------
// Elements enter on the input channel (in_valid / in_stall) one word each, in
// row-major order. For every nonzero element one word leaves on the output
// channel (out_valid / out_stall) with coord0..coord3 and hit_ordinal; zero
// elements produce nothing. Coordinates of unused dimensions are zero.
// Configuration registers are written through cfg_valid / cfg_ready with
// cfg_index and cfg_data; the user must write them only while no element is in
// flight, and the block itself does not enforce this; cfg_ready is always high.
// From input accept to output valid an element passes an input register, then
// the zero test and coordinate step into the output register. One element is
// accepted every cycle while in_stall is low. While the receiver stalls, the
// input register still takes one more word; a zero element there passes
// through even then, a nonzero one waits and stalls the input side.
// Reset clears the coordinates, the nonzero count and both valid flags, and
// sets element kind integer, one dimension and all extents to one.
// ----------------------------------------------------------------------------
module nonzero_coordinate_emitter (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [nze_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nze_pkg::CFG_DATA_W-1:0] cfg_data,

	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [nze_pkg::ELEM_W-1:0]     element_bits,

	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [nze_pkg::FIELD_W-1:0]    coord0,
	output logic [nze_pkg::FIELD_W-1:0]    coord1,
	output logic [nze_pkg::FIELD_W-1:0]    coord2,
	output logic [nze_pkg::FIELD_W-1:0]    coord3,
	output logic [nze_pkg::ORD_W-1:0]      hit_ordinal
);
	import nze_pkg::*;

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [ELEM_W-1:0] bits_s1;
	logic              nz_s1;
	logic              adv_s1;
	hit_t              hit;
	logic              valid_s2;
	hit_t              hit_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind   <= KIND_INT;
			cfg_q.dims   <= DIMS_W'(1);
			cfg_q.extent <= {EXTENT_REGS{FIELD_W'(1)}};
		end else if (cfg_valid && cfg_ready) begin
			priority case (cfg_index)
				REG_ELEMENT_KIND: cfg_q.kind      <= cfg_data[2:0];
				REG_DIMS_IN_USE:  cfg_q.dims      <= cfg_data[DIMS_W-1:0];
				REG_EXTENT_DIM0:  cfg_q.extent[0] <= cfg_data;
				REG_EXTENT_DIM1:  cfg_q.extent[1] <= cfg_data;
				REG_EXTENT_DIM2:  cfg_q.extent[2] <= cfg_data;
				REG_EXTENT_DIM3:  cfg_q.extent[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	nze_zero_test u_zero_test (
		.element_bits (bits_s1),
		.kind         (cfg_q.kind),
		.nonzero      (nz_s1)
	);

	nze_coord_counter u_coord_counter (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.step    (adv_s1),
		.nonzero (nz_s1),
		.hit     (hit)
	);

	// A zero element never needs the output register, so it always advances.
	assign adv_s1   = valid_s1 && (!nz_s1 || !valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1 && nz_s1) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			bits_s1 <= element_bits;
		end
		if (adv_s1 && nz_s1) begin
			hit_s2 <= hit;
		end
	end

	assign out_valid   = valid_s2;
	assign coord0      = hit_s2.coords[0];
	assign coord1      = hit_s2.coords[1];
	assign coord2      = hit_s2.coords[2];
	assign coord3      = hit_s2.coords[3];
	assign hit_ordinal = hit_s2.ordinal;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_hit_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && nz_s1) |=> valid_s2)
		else $error("nonzero element did not reach the output register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |-> !(adv_s1 && nz_s1))
		else $error("waiting result overwritten");

endmodule

// ===== dv/nonzero_coordinate_emitter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonzero_coordinate_emitter_tb
// Self-checking bench for the nonzero coordinate emitter.
// ----------------------------------------------------------------------------
// A short table of directed elements and register writes covers every element
// kind, signed zeros, NaN, the scalar case, saturated dimension counts, zero
// extents and an extent lowered to the running counter. Random phases follow,
// each with a fresh register setting. A local coordinate tracker predicts every
// output word, and each word leaving the block is compared field by field
// with the oldest prediction. Both sides idle in random bursts, and once the
// receiver holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module nonzero_coordinate_emitter_tb;

	import nze_pkg::*;

	localparam logic [2:0]           KIND_UNDEFINED = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI   = 3'd7;

	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_CYCLES     = 200;
	localparam int QUIET_LIMIT     = 4000;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 143;

	typedef struct packed {
		logic typed;
		logic has_hit;
		hit_t hit;
	} elem_note_t;

	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [ELEM_W-1:0]     bits;
		elem_note_t            note;
	} drive_row_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [ELEM_W-1:0]     element_bits = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [FIELD_W-1:0]    coord0;
	logic [FIELD_W-1:0]    coord1;
	logic [FIELD_W-1:0]    coord2;
	logic [FIELD_W-1:0]    coord3;
	logic [ORD_W-1:0]      hit_ordinal;

	// Local copy of the block's registers and counters.
	logic [2:0]         m_kind;
	logic [DIMS_W-1:0]  m_dims;
	logic [FIELD_W-1:0] m_ext [EXTENT_REGS];
	logic [FIELD_W-1:0] m_pos [OUT_DIMS];
	logic [ORD_W-1:0]   m_hits;

	hit_t       pending_hits [$];
	elem_note_t offered_notes [$];
	drive_row_t directed_rows [$];

	bit send_idle     = 1'b0;
	bit recv_idle     = 1'b0;
	bit hold_request  = 1'b0;
	int error_count   = 0;

	nonzero_coordinate_emitter DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.element_bits(element_bits),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.coord0      (coord0),
		.coord1      (coord1),
		.coord2      (coord2),
		.coord3      (coord3),
		.hit_ordinal (hit_ordinal)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_ELEMENT_KIND: m_kind = data[2:0];
			REG_DIMS_IN_USE:  m_dims = data[DIMS_W-1:0];
			REG_EXTENT_DIM0:  m_ext[0] = data;
			REG_EXTENT_DIM1:  m_ext[1] = data;
			REG_EXTENT_DIM2:  m_ext[2] = data;
			REG_EXTENT_DIM3:  m_ext[3] = data;
			default: ;
		endcase
	endfunction

	function automatic void step_coordinates(input logic [ELEM_W-1:0] bits,
			output logic produced, output hit_t hit);
		int         nd;
		logic       nonzero;
		logic       carry;
		logic [FIELD_W:0] nxt;
		nd = (m_dims > ACT_DIMS) ? ACT_DIMS : int'(m_dims);
		for (int d = 0; d < OUT_DIMS; d++)
			if (d >= nd)
				m_pos[d] = '0;
		case (m_kind)
			KIND_FP16, KIND_BF16: nonzero = |bits[14:0];
			KIND_FP32:            nonzero = |bits[30:0];
			KIND_FP64:            nonzero = |bits[62:0];
			KIND_CPLX_FP32:       nonzero = (|bits[30:0]) || (|bits[62:32]);
			default:              nonzero = |bits;
		endcase
		hit = '0;
		produced = nonzero;
		if (nonzero) begin
			for (int d = 0; d < OUT_DIMS; d++)
				hit.coords[d] = (d < nd) ? m_pos[d] : '0;
			hit.ordinal = m_hits;
			m_hits = m_hits + 1'b1;
		end
		// The innermost dimension steps first; a carry moves outward.
		carry = 1'b1;
		for (int d = OUT_DIMS - 1; d >= 0; d--) begin
			if (carry && d < nd) begin
				nxt = {1'b0, m_pos[d]} + 1'b1;
				if (nxt < {1'b0, m_ext[d]}) begin
					m_pos[d] = nxt[FIELD_W-1:0];
					carry = 1'b0;
				end else begin
					m_pos[d] = '0;
				end
			end
		end
		if (carry)
			m_hits = '0;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Prediction and checking, both sampled at the same edge as the DUT.
	always @(posedge clk) begin : scoreboard
		elem_note_t note;
		logic       produced;
		hit_t       predicted;
		hit_t       want;
		if (!arst_n) begin
			m_kind = KIND_INT;
			m_dims = DIMS_W'(1);
			m_hits = '0;
			for (int d = 0; d < OUT_DIMS; d++) begin
				m_ext[d] = FIELD_W'(1);
				m_pos[d] = '0;
			end
		end else begin
			if (cfg_valid && cfg_ready)
				apply_setting(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				note = offered_notes.pop_front();
				step_coordinates(element_bits, produced, predicted);
				if (note.typed) begin
					if (note.has_hit)
						pending_hits.push_back(note.hit);
				end else if (produced) begin
					pending_hits.push_back(predicted);
				end
			end
			if (out_valid && !out_stall) begin
				if (pending_hits.size() == 0) begin
					error_count++;
					$display("%0t: word not expected, expected none, actual %0d %0d %0d %0d ord %0d",
						$time, coord0, coord1, coord2, coord3, hit_ordinal);
				end else begin
					want = pending_hits.pop_front();
					compare_field("coord0", 32'(want.coords[0]), 32'(coord0));
					compare_field("coord1", 32'(want.coords[1]), 32'(coord1));
					compare_field("coord2", 32'(want.coords[2]), 32'(coord2));
					compare_field("coord3", 32'(want.coords[3]), 32'(coord3));
					compare_field("hit_ordinal", 32'(want.ordinal), 32'(hit_ordinal));
				end
			end
		end
	end

	// Receiver side: random stall bursts, plus one long hold on request.
	initial begin : receiver
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (recv_idle && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	function automatic drive_row_t setting_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		drive_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	// Typed rows are all taken where every element wraps, so a hit is all zeros.
	function automatic drive_row_t element_row(input logic [ELEM_W-1:0] bits,
			input logic typed, input logic has_hit);
		drive_row_t row;
		row = '0;
		row.bits = bits;
		row.note.typed = typed;
		row.note.has_hit = has_hit;
		return row;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_extent();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return CFG_DATA_W'($urandom_range(1, 65535));
			default: return CFG_DATA_W'($urandom_range(1, 5));
		endcase
	endfunction

	function automatic logic [ELEM_W-1:0] random_element(input logic [2:0] kind);
		logic [ELEM_W-1:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return '0;
			4: begin
				// Only the bits that the zero test ignores: signed or padded zeros.
				case (kind)
					KIND_FP16, KIND_BF16: return raw & ~64'h7FFF;
					KIND_FP32:            return raw & ~64'h7FFF_FFFF;
					KIND_FP64:            return raw & 64'h8000_0000_0000_0000;
					KIND_CPLX_FP32:       return raw & 64'h8000_0000_8000_0000;
					default:              return '0;
				endcase
			end
			5:       return 64'd1 << $urandom_range(0, 63);
			6:       return '1;
			default: return raw;
		endcase
	endfunction

	task automatic settle_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high so that back-to-back writes follow without a gap.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic offer_element(input logic [ELEM_W-1:0] bits, input elem_note_t note);
		cfg_valid <= 1'b0;
		if (send_idle && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		offered_notes.push_back(note);
		in_valid <= 1'b1;
		element_bits <= bits;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin : stimulus
		logic [2:0] kind;
		logic [2:0] dims;
		elem_note_t free_note;

		free_note = '0;

		// Reset settings: integer kind, one dimension of extent one.
		directed_rows.push_back(element_row(64'h0, 1'b1, 1'b0));
		directed_rows.push_back(element_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1));
		directed_rows.push_back(element_row(64'h8000_0000_0000_0000, 1'b1, 1'b1));
		directed_rows.push_back(setting_row(REG_ELEMENT_KIND, CFG_DATA_W'(KIND_FP16)));
		directed_rows.push_back(element_row(64'h8000, 1'b1, 1'b0));
		directed_rows.push_back(element_row(64'hFFFF_FFFF_FFFF_0000, 1'b1, 1'b0));
		directed_rows.push_back(element_row(64'h7C01, 1'b1, 1'b1));
		directed_rows.push_back(setting_row(REG_ELEMENT_KIND, CFG_DATA_W'(KIND_BF16)));
		directed_rows.push_back(element_row(64'h0001, 1'b1, 1'b1));
		directed_rows.push_back(element_row(64'h8000, 1'b1, 1'b0));
		directed_rows.push_back(setting_row(REG_ELEMENT_KIND, CFG_DATA_W'(KIND_FP32)));
		directed_rows.push_back(element_row(64'hFFFF_FFFF_8000_0000, 1'b1, 1'b0));
		directed_rows.push_back(element_row(64'h7FFF_FFFF, 1'b1, 1'b1));
		directed_rows.push_back(setting_row(REG_ELEMENT_KIND, CFG_DATA_W'(KIND_FP64)));
		directed_rows.push_back(element_row(64'h8000_0000_0000_0000, 1'b1, 1'b0));
		directed_rows.push_back(element_row(64'h0000_0001_0000_0000, 1'b1, 1'b1));
		directed_rows.push_back(setting_row(REG_ELEMENT_KIND, CFG_DATA_W'(KIND_CPLX_FP32)));
		directed_rows.push_back(element_row(64'h8000_0000_8000_0000, 1'b1, 1'b0));
		directed_rows.push_back(element_row(64'h0000_0001_0000_0000, 1'b1, 1'b1));
		directed_rows.push_back(element_row(64'h0000_0000_0000_0001, 1'b1, 1'b1));
		// Undefined kinds fall back to the integer test.
		directed_rows.push_back(setting_row(REG_ELEMENT_KIND, CFG_DATA_W'(KIND_UNDEFINED)));
		directed_rows.push_back(element_row(64'h8000_0000_0000_0000, 1'b1, 1'b1));
		// Scalar: every element is the whole tensor.
		directed_rows.push_back(setting_row(REG_ELEMENT_KIND, CFG_DATA_W'(KIND_INT)));
		directed_rows.push_back(setting_row(REG_DIMS_IN_USE, 16'd0));
		directed_rows.push_back(element_row(64'h5, 1'b1, 1'b1));
		directed_rows.push_back(element_row(64'h6, 1'b1, 1'b1));
		directed_rows.push_back(setting_row(REG_DIMS_IN_USE, 16'd2));
		directed_rows.push_back(setting_row(REG_EXTENT_DIM0, 16'd2));
		directed_rows.push_back(setting_row(REG_EXTENT_DIM1, 16'd3));
		directed_rows.push_back(element_row(64'h1, 1'b0, 1'b0));
		directed_rows.push_back(element_row(64'h0, 1'b0, 1'b0));
		directed_rows.push_back(element_row(64'h2, 1'b0, 1'b0));
		directed_rows.push_back(element_row(64'h3, 1'b0, 1'b0));
		// Inner extent drops to the value of the running counter.
		directed_rows.push_back(setting_row(REG_EXTENT_DIM1, 16'd1));
		directed_rows.push_back(element_row(64'h7, 1'b0, 1'b0));
		// Dimension count above the maximum, a zero extent and the largest one.
		directed_rows.push_back(setting_row(REG_DIMS_IN_USE, 16'd7));
		directed_rows.push_back(setting_row(REG_EXTENT_DIM2, 16'd0));
		directed_rows.push_back(setting_row(REG_EXTENT_DIM3, 16'hFFFF));
		directed_rows.push_back(setting_row(REG_SPARE_LO, 16'hFFFF));
		directed_rows.push_back(setting_row(REG_SPARE_HI, 16'h5A5A));
		directed_rows.push_back(element_row(64'h9, 1'b0, 1'b0));
		directed_rows.push_back(element_row(64'h9, 1'b0, 1'b0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < directed_rows.size(); i++) begin
			if (directed_rows[i].is_cfg) begin
				if (i == 0 || !directed_rows[i-1].is_cfg)
					settle_pipeline();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				offer_element(directed_rows[i].bits, directed_rows[i].note);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle_pipeline();
			kind = 3'($urandom_range(0, 7));
			dims = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(1, 4));
			write_reg(REG_ELEMENT_KIND, {13'($urandom), kind});
			write_reg(REG_DIMS_IN_USE, {13'($urandom), dims});
			write_reg(REG_EXTENT_DIM0, random_extent());
			write_reg(REG_EXTENT_DIM1, random_extent());
			write_reg(REG_EXTENT_DIM2, random_extent());
			write_reg(REG_EXTENT_DIM3, random_extent());
			// First phase: the receiver holds off while the sender keeps pushing.
			send_idle = (p > 0 && p < PHASES - 2);
			recv_idle = (p > 0 && p < PHASES - 2);
			if (p == 0)
				hold_request = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				offer_element(random_element(kind), free_note);
		end

		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_hits.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
src/nze_pkg.sv
src/nze_zero_test.sv
src/nze_coord_counter.sv
src/nonzero_coordinate_emitter.sv
dv/nonzero_coordinate_emitter_tb.sv
